// File: hw/rtl/bba_pkg.sv
// Shared constants, codes and types of the buddy block allocator.
`default_nettype none
package bba_pkg;

   localparam int DEF_ATOMS  = 1024;
   localparam int DEF_LEVELS = 11;

   localparam int MIN_W  = 5;
   localparam int LVL_W  = 4;
   localparam int ATM_W  = 11;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;

   localparam logic [MIN_W-1:0] MIN_RESET = 5'd6;
   localparam logic [LVL_W-1:0] LVL_RESET = 4'd11;
   localparam logic [ATM_W-1:0] ATM_RESET = 11'd1024;
   localparam logic [MIN_W-1:0] MIN_LIMIT = 5'd20;

   localparam logic [1:0] REG_MIN = 2'd0;
   localparam logic [1:0] REG_LVL = 2'd1;
   localparam logic [1:0] REG_ATM = 2'd2;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_INIT   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_BIG  = 2'd1;
   localparam logic [1:0] ST_NO_MEM   = 2'd2;
   localparam logic [1:0] ST_INVALID  = 2'd3;

   typedef struct packed {
      logic [MIN_W-1:0] min_size_log2;
      logic [LVL_W-1:0] level_count;
      logic [ATM_W-1:0] atom_count;
      logic             valid;
   } cfg_type;

endpackage
`default_nettype wire

// File: hw/rtl/bba_csr.sv
// Configuration registers with their APB-style port and the validity check.
`default_nettype none
module bba_csr #(
   parameter int ATOMS  = bba_pkg::DEF_ATOMS,
   parameter int LEVELS = bba_pkg::DEF_LEVELS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [bba_pkg::ADDR_W-1:0] paddr,
   input  wire logic [bba_pkg::DATA_W-1:0] pwdata,
   output logic      [bba_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   output bba_pkg::cfg_type                cfg
);
   import bba_pkg::*;

   logic [MIN_W-1:0] min_ff, min_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [ATM_W-1:0] atm_ff, atm_in;
   logic             wr_en;
   logic [5:0]       top_log2;
   logic [16:0]      blk;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      min_in = min_ff;
      lvl_in = lvl_ff;
      atm_in = atm_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_MIN: min_in = pwdata[MIN_W-1:0];
            REG_LVL: lvl_in = pwdata[LVL_W-1:0];
            REG_ATM: atm_in = pwdata[ATM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_RESET;
         lvl_ff <= LVL_RESET;
         atm_ff <= ATM_RESET;
      end else begin
         min_ff <= min_in;
         lvl_ff <= lvl_in;
         atm_ff <= atm_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_MIN: prdata = DATA_W'(min_ff);
         REG_LVL: prdata = DATA_W'(lvl_ff);
         REG_ATM: prdata = DATA_W'(atm_ff);
         default: prdata = '0;
      endcase
   end

   // Size of one largest block in atoms and the log2 of its size in bytes.
   assign top_log2 = 6'(min_ff) + 6'(lvl_ff) - 6'd1;
   assign blk      = 17'd1 << (lvl_ff - 4'd1);

   always_comb begin
      cfg.min_size_log2 = min_ff;
      cfg.level_count   = lvl_ff;
      cfg.atom_count    = atm_ff;
      cfg.valid = (lvl_ff != '0) && (32'(lvl_ff) <= 32'(LEVELS)) &&
                  (atm_ff != '0) && (32'(atm_ff) <= 32'(ATOMS)) &&
                  (min_ff <= MIN_LIMIT) && (top_log2 <= 6'd31) &&
                  (17'(atm_ff) >= blk);
   end

endmodule
`default_nettype wire

// File: hw/rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: command sequencer and metadata memories.
`default_nettype none
// The allocator hands out power-of-two blocks from a pool of up to ATOMS
// atoms, each atom being 2^min_size_log2 bytes. A command beat is taken
// when start is high and busy is low; busy then stays high until the single
// result beat is shown on the rsp_ ports for one cycle under rsp_valid, and
// is low again in that cycle. The receiver cannot hold a result off, so it
// must take it in that cycle. Work is done by one small sequencer that
// drives a shared shift, compare and link-update datapath over per-atom
// metadata memories. An allocate rounds the size up one level at a time,
// searches upward for a non-empty level, pops the list head and splits it
// down to the wanted level. A free merges with its buddy while that buddy
// is free, then pushes the result. An initialize sweeps every atom once.
// After reset the same sweep runs with the reset configuration, so busy
// stays high through it before the first command can be taken; configuration
// writes are accepted at any time and take effect at the next initialize.
// A command code that means nothing returns status invalid.
module buddy_block_allocator #(
   parameter int ATOMS  = bba_pkg::DEF_ATOMS,
   parameter int LEVELS = bba_pkg::DEF_LEVELS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_opcode,
   input  wire logic [31:0]                req_request_size,
   input  wire logic [31:0]                req_free_offset,
   output logic                            rsp_valid,
   output logic      [1:0]                 rsp_status,
   output logic      [31:0]                rsp_block_offset,
   output logic      [31:0]                rsp_block_size,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [bba_pkg::ADDR_W-1:0] paddr,
   input  wire logic [bba_pkg::DATA_W-1:0] pwdata,
   output logic      [bba_pkg::DATA_W-1:0] prdata,
   output logic                            pready
);
   import bba_pkg::*;

   localparam int AW  = $clog2(ATOMS);
   localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SW  = 5;

   localparam logic [SW-1:0] S_IDLE     = 5'd0;
   localparam logic [SW-1:0] S_INIT_CHK = 5'd1;
   localparam logic [SW-1:0] S_SWEEP    = 5'd2;
   localparam logic [SW-1:0] S_A_CHK    = 5'd3;
   localparam logic [SW-1:0] S_A_SIZE   = 5'd4;
   localparam logic [SW-1:0] S_A_SEARCH = 5'd5;
   localparam logic [SW-1:0] S_A_SPLIT  = 5'd6;
   localparam logic [SW-1:0] S_A_DONE   = 5'd7;
   localparam logic [SW-1:0] S_F_CHK    = 5'd8;
   localparam logic [SW-1:0] S_F_USE    = 5'd9;
   localparam logic [SW-1:0] S_F_LOOP   = 5'd10;
   localparam logic [SW-1:0] S_F_BUD    = 5'd11;
   localparam logic [SW-1:0] S_F_MERGE  = 5'd12;
   localparam logic [SW-1:0] S_F_PUSH   = 5'd13;
   localparam logic [SW-1:0] S_F_DONE   = 5'd14;
   localparam logic [SW-1:0] S_UNL_RD   = 5'd15;
   localparam logic [SW-1:0] S_UNL_W1   = 5'd16;
   localparam logic [SW-1:0] S_UNL_W2   = 5'd17;
   localparam logic [SW-1:0] S_PSH_1    = 5'd18;
   localparam logic [SW-1:0] S_PSH_2    = 5'd19;
   localparam logic [SW-1:0] S_ERR      = 5'd20;

   cfg_type cfg;

   bba_csr #(.ATOMS(ATOMS), .LEVELS(LEVELS)) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   // Per-atom metadata memories. Links are only meaningful under their
   // has-prev and has-next bits, so stale link values are never looked at.
   logic [AW-1:0]    prev_mem [ATOMS];
   logic [AW-1:0]    next_mem [ATOMS];
   logic             hp_mem   [ATOMS];
   logic             hn_mem   [ATOMS];
   logic             onf_mem  [ATOMS];
   logic             use_mem  [ATOMS];
   logic [LVL_W-1:0] lvl_mem  [ATOMS];

   logic             prev_we, next_we, hp_we, hn_we, onf_we, use_we, lvl_we;
   logic [AW-1:0]    prev_wa, next_wa, hp_wa, hn_wa, onf_wa, use_wa, lvl_wa;
   logic [AW-1:0]    prev_wd, next_wd;
   logic             hp_wd, hn_wd, onf_wd, use_wd;
   logic [LVL_W-1:0] lvl_wd;

   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    rd_prev_ff, rd_next_ff;
   logic             rd_hp_ff, rd_hn_ff, rd_onf_ff, rd_use_ff;
   logic [LVL_W-1:0] rd_lvl_ff;

   // Free list heads and their non-empty bits, one per level.
   logic [AW-1:0]     head_ff [LEVELS];
   logic [AW-1:0]     head_in [LEVELS];
   logic [LEVELS-1:0] busy_ff, busy_in;

   logic [SW-1:0]    state_ff, state_in, ret_ff, ret_in;
   logic [AW-1:0]    cur_ff, cur_in, tgt_ff, tgt_in, cnt_ff, cnt_in;
   logic [LVL_W-1:0] lv_ff, lv_in, want_ff, want_in, tlv_ff, tlv_in;
   logic [31:0]      arg_ff, arg_in;
   logic             init_rsp_ff, init_rsp_in;

   logic             act_ok_ff, act_ok_in;
   logic [MIN_W-1:0] act_min_ff, act_min_in;
   logic [LVL_W-1:0] act_lvl_ff, act_lvl_in;
   logic [ATM_W-1:0] act_atm_ff, act_atm_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_off_ff, rsp_off_in, rsp_size_ff, rsp_size_in;

   // Shared shift and compare datapath.
   logic [31:0] buddy;
   logic [31:0] slot32;
   logic [31:0] blk32, limit32, atom32;
   logic        sweep_start;
   logic [LVL_W-1:0] lv_dn;

   assign lv_dn  = lv_ff - 4'd1;
   assign buddy  = 32'(cur_ff) ^ (32'd1 << ((state_ff == S_A_SPLIT) ? lv_dn : lv_ff));
   assign slot32 = arg_ff >> act_min_ff;

   assign blk32       = 32'd1 << (act_lvl_ff - 4'd1);
   assign limit32     = 32'(act_atm_ff) & ~(blk32 - 32'd1);
   assign atom32      = 32'(cnt_ff);
   assign sweep_start = act_ok_ff && ((atom32 & (blk32 - 32'd1)) == '0) &&
                        (atom32 < limit32);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      cnt_in        = cnt_ff;
      lv_in         = lv_ff;
      want_in       = want_ff;
      tlv_in        = tlv_ff;
      arg_in        = arg_ff;
      init_rsp_in   = init_rsp_ff;
      act_ok_in     = act_ok_ff;
      act_min_in    = act_min_ff;
      act_lvl_in    = act_lvl_ff;
      act_atm_in    = act_atm_ff;
      head_in       = head_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_size_in   = rsp_size_ff;
      rd_addr       = tgt_ff;

      prev_we = 1'b0;  prev_wa = tgt_ff;  prev_wd = '0;
      next_we = 1'b0;  next_wa = tgt_ff;  next_wd = '0;
      hp_we   = 1'b0;  hp_wa   = tgt_ff;  hp_wd   = 1'b0;
      hn_we   = 1'b0;  hn_wa   = tgt_ff;  hn_wd   = 1'b0;
      onf_we  = 1'b0;  onf_wa  = tgt_ff;  onf_wd  = 1'b0;
      use_we  = 1'b0;  use_wa  = cur_ff;  use_wd  = 1'b0;
      lvl_we  = 1'b0;  lvl_wa  = tgt_ff;  lvl_wd  = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_ALLOC: begin
                     arg_in   = req_request_size;
                     state_in = S_A_CHK;
                  end
                  OP_FREE: begin
                     arg_in   = req_free_offset;
                     state_in = S_F_CHK;
                  end
                  OP_INIT: begin
                     init_rsp_in = 1'b1;
                     state_in    = S_INIT_CHK;
                  end
                  default: state_in = S_ERR;
               endcase
            end
         end

         S_ERR: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_INVALID;
            rsp_off_in    = '0;
            rsp_size_in   = '0;
            state_in      = S_IDLE;
         end

         S_INIT_CHK: begin
            act_ok_in  = cfg.valid;
            act_min_in = cfg.min_size_log2;
            act_lvl_in = cfg.level_count;
            act_atm_in = cfg.atom_count;
            busy_in    = '0;
            if (cfg.valid) begin
               head_in[LIW'(cfg.level_count - 4'd1)] = '0;
               busy_in[LIW'(cfg.level_count - 4'd1)] = 1'b1;
            end
            cnt_in   = '0;
            state_in = S_SWEEP;
         end

         // Every largest block that fits in the configured atoms is chained in
         // ascending order; all other atoms are cleared.
         S_SWEEP: begin
            prev_we = 1'b1;  prev_wa = cnt_ff;  prev_wd = AW'(atom32 - blk32);
            next_we = 1'b1;  next_wa = cnt_ff;  next_wd = AW'(atom32 + blk32);
            hp_we   = 1'b1;  hp_wa   = cnt_ff;  hp_wd   = sweep_start && (cnt_ff != '0);
            hn_we   = 1'b1;  hn_wa   = cnt_ff;
            hn_wd   = sweep_start && ((atom32 + blk32) < limit32);
            onf_we  = 1'b1;  onf_wa  = cnt_ff;  onf_wd  = sweep_start;
            use_we  = 1'b1;  use_wa  = cnt_ff;  use_wd  = 1'b0;
            lvl_we  = 1'b1;  lvl_wa  = cnt_ff;
            lvl_wd  = sweep_start ? (act_lvl_ff - 4'd1) : '0;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == AW'(ATOMS - 1)) begin
               if (init_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = act_ok_ff ? ST_OK : ST_INVALID;
                  rsp_off_in    = '0;
                  rsp_size_in   = '0;
               end
               init_rsp_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         S_A_CHK: begin
            rsp_off_in  = '0;
            rsp_size_in = '0;
            if (!act_ok_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_MEM;
               state_in      = S_IDLE;
            end else if ({1'b0, arg_ff} >
                         (33'd1 << (6'(act_min_ff) + 6'(act_lvl_ff) - 6'd1))) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_TOO_BIG;
               state_in      = S_IDLE;
            end else begin
               want_in  = '0;
               state_in = S_A_SIZE;
            end
         end

         // Round up to a power of two, one level a cycle.
         S_A_SIZE: begin
            if ((33'd1 << (6'(act_min_ff) + 6'(want_ff))) < {1'b0, arg_ff}) begin
               want_in = want_ff + 4'd1;
            end else begin
               lv_in    = want_ff;
               state_in = S_A_SEARCH;
            end
         end

         S_A_SEARCH: begin
            if (lv_ff >= act_lvl_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_MEM;
               rsp_off_in    = '0;
               rsp_size_in   = '0;
               state_in      = S_IDLE;
            end else if (busy_ff[LIW'(lv_ff)]) begin
               cur_in   = head_ff[LIW'(lv_ff)];
               tgt_in   = head_ff[LIW'(lv_ff)];
               ret_in   = S_A_SPLIT;
               state_in = S_UNL_RD;
            end else begin
               lv_in = lv_ff + 4'd1;
            end
         end

         // Push each right buddy one level down until the wanted level.
         S_A_SPLIT: begin
            if (lv_ff > want_ff) begin
               lv_in = lv_dn;
               if (buddy >= 32'(ATOMS)) begin
                  state_in = S_A_DONE;
               end else begin
                  tgt_in   = AW'(buddy);
                  tlv_in   = lv_dn;
                  ret_in   = S_A_SPLIT;
                  state_in = S_PSH_1;
               end
            end else begin
               state_in = S_A_DONE;
            end
         end

         S_A_DONE: begin
            use_we        = 1'b1;  use_wa = cur_ff;  use_wd = 1'b1;
            lvl_we        = 1'b1;  lvl_wa = cur_ff;  lvl_wd = lv_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_off_in    = 32'(cur_ff) << act_min_ff;
            rsp_size_in   = 32'd1 << (6'(act_min_ff) + 6'(lv_ff));
            state_in      = S_IDLE;
         end

         S_F_CHK: begin
            rsp_off_in  = '0;
            rsp_size_in = '0;
            if (!act_ok_ff ||
                ({1'b0, arg_ff} >= (33'(act_atm_ff) << act_min_ff)) ||
                (slot32 >= 32'(ATOMS))) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INVALID;
               state_in      = S_IDLE;
            end else begin
               cur_in   = AW'(slot32);
               rd_addr  = AW'(slot32);
               state_in = S_F_USE;
            end
         end

         S_F_USE: begin
            if (!rd_use_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INVALID;
               state_in      = S_IDLE;
            end else begin
               use_we   = 1'b1;  use_wa = cur_ff;  use_wd = 1'b0;
               lv_in    = rd_lvl_ff;
               state_in = S_F_LOOP;
            end
         end

         S_F_LOOP: begin
            if ((5'(lv_ff) + 5'd1) < 5'(act_lvl_ff)) begin
               if (buddy >= 32'(ATOMS)) begin
                  state_in = S_F_PUSH;
               end else begin
                  tgt_in   = AW'(buddy);
                  rd_addr  = AW'(buddy);
                  state_in = S_F_BUD;
               end
            end else begin
               state_in = S_F_PUSH;
            end
         end

         S_F_BUD: begin
            if (!rd_onf_ff || (rd_lvl_ff < lv_ff)) begin
               state_in = S_F_PUSH;
            end else begin
               ret_in   = S_F_MERGE;
               state_in = S_UNL_RD;
            end
         end

         S_F_MERGE: begin
            if (tgt_ff < cur_ff) begin
               cur_in = tgt_ff;
            end
            lv_in    = lv_ff + 4'd1;
            state_in = S_F_LOOP;
         end

         S_F_PUSH: begin
            tgt_in   = cur_ff;
            tlv_in   = lv_ff;
            ret_in   = S_F_DONE;
            state_in = S_PSH_1;
         end

         S_F_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end

         // Unlink: read the entry, patch its neighbours, then clear it.
         S_UNL_RD: begin
            rd_addr  = tgt_ff;
            state_in = S_UNL_W1;
         end

         S_UNL_W1: begin
            if (rd_hp_ff) begin
               next_we = 1'b1;  next_wa = rd_prev_ff;  next_wd = rd_next_ff;
               hn_we   = 1'b1;  hn_wa   = rd_prev_ff;  hn_wd   = rd_hn_ff;
            end else begin
               head_in[LIW'(rd_lvl_ff)] = rd_next_ff;
               busy_in[LIW'(rd_lvl_ff)] = rd_hn_ff;
            end
            if (rd_hn_ff) begin
               prev_we = 1'b1;  prev_wa = rd_next_ff;  prev_wd = rd_prev_ff;
               hp_we   = 1'b1;  hp_wa   = rd_next_ff;  hp_wd   = rd_hp_ff;
            end
            state_in = S_UNL_W2;
         end

         S_UNL_W2: begin
            hp_we    = 1'b1;  hp_wa  = tgt_ff;  hp_wd  = 1'b0;
            hn_we    = 1'b1;  hn_wa  = tgt_ff;  hn_wd  = 1'b0;
            onf_we   = 1'b1;  onf_wa = tgt_ff;  onf_wd = 1'b0;
            state_in = ret_ff;
         end

         // Push onto the head of the list of level tlv.
         S_PSH_1: begin
            lvl_we = 1'b1;  lvl_wa = tgt_ff;  lvl_wd = tlv_ff;
            onf_we = 1'b1;  onf_wa = tgt_ff;  onf_wd = 1'b1;
            hn_we  = 1'b1;  hn_wa  = tgt_ff;  hn_wd  = busy_ff[LIW'(tlv_ff)];
            if (busy_ff[LIW'(tlv_ff)]) begin
               next_we = 1'b1;  next_wa = tgt_ff;  next_wd = head_ff[LIW'(tlv_ff)];
               prev_we = 1'b1;  prev_wa = head_ff[LIW'(tlv_ff)];  prev_wd = tgt_ff;
               hp_we   = 1'b1;  hp_wa   = head_ff[LIW'(tlv_ff)];  hp_wd   = 1'b1;
            end
            head_in[LIW'(tlv_ff)] = tgt_ff;
            busy_in[LIW'(tlv_ff)] = 1'b1;
            state_in = S_PSH_2;
         end

         S_PSH_2: begin
            hp_we    = 1'b1;  hp_wa = tgt_ff;  hp_wd = 1'b0;
            state_in = ret_ff;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_CHK;
         init_rsp_ff  <= 1'b0;
         act_ok_ff    <= 1'b0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_rsp_ff  <= init_rsp_in;
         act_ok_ff    <= act_ok_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      cur_ff        <= cur_in;
      tgt_ff        <= tgt_in;
      cnt_ff        <= cnt_in;
      lv_ff         <= lv_in;
      want_ff       <= want_in;
      tlv_ff        <= tlv_in;
      arg_ff        <= arg_in;
      act_min_ff    <= act_min_in;
      act_lvl_ff    <= act_lvl_in;
      act_atm_ff    <= act_atm_in;
      head_ff       <= head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_size_ff   <= rsp_size_in;
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (hp_we)   hp_mem[hp_wa]     <= hp_wd;
      if (hn_we)   hn_mem[hn_wa]     <= hn_wd;
      if (onf_we)  onf_mem[onf_wa]   <= onf_wd;
      if (use_we)  use_mem[use_wa]   <= use_wd;
      if (lvl_we)  lvl_mem[lvl_wa]   <= lvl_wd;
      rd_prev_ff <= prev_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
      rd_hp_ff   <= hp_mem[rd_addr];
      rd_hn_ff   <= hn_mem[rd_addr];
      rd_onf_ff  <= onf_mem[rd_addr];
      rd_use_ff  <= use_mem[rd_addr];
      rd_lvl_ff  <= lvl_mem[rd_addr];
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_size   = rsp_size_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bba_checker.sv
// Port-level checks of the buddy block allocator and their binding.
`default_nettype none
module bba_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_block_offset,
   input wire logic [31:0] rsp_block_size
);
   import bba_pkg::*;

   // A result beat only ever closes a command that kept the block busy.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a command in progress");

   // A taken command always makes the block busy in the following cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command taken but block not busy");

   // One result per command: result beats never come back to back.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in successive cycles");

   // Failed commands report no block.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
      ((rsp_block_offset == '0) && (rsp_block_size == '0)))
      else $error("failed command reports a block");

endmodule

bind buddy_block_allocator bba_props u_bba_props (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_block_offset(rsp_block_offset),
   .rsp_block_size  (rsp_block_size)
);
`default_nettype wire
